[rtl/grti_pkg.sv]
// Shared types, widths and constants of the gradient ramp texel interpolator.
package grti_pkg;

   localparam int MAX_STOPS_DEF = 16;
   localparam int TEXELS_DEF    = 4096;

   localparam int POS_W     = 16;
   localparam int COL_W     = 16;
   localparam int IDX_W     = 12;
   localparam int SLOT_W    = 4;
   localparam int CNT_CFG_W = 5;
   localparam int OUT_W     = 8;
   localparam int W_W       = 17;
   localparam int PROD_W    = 32;
   localparam int MUL_W     = 18;

   localparam logic OP_WRITE = 1'b0;
   localparam logic OP_TEXEL = 1'b1;

   typedef struct packed {
      logic                 op;
      logic [SLOT_W-1:0]    slot;
      logic [POS_W-1:0]     stop_position;
      logic [COL_W-1:0]     stop_red;
      logic [COL_W-1:0]     stop_green;
      logic [COL_W-1:0]     stop_blue;
      logic [COL_W-1:0]     stop_alpha;
      logic [IDX_W-1:0]     texel_index;
   } req_type;

   typedef struct packed {
      logic [IDX_W-1:0] out_index;
      logic [OUT_W-1:0] out_red;
      logic [OUT_W-1:0] out_green;
      logic [OUT_W-1:0] out_blue;
      logic [OUT_W-1:0] out_alpha;
   } rsp_type;

   // col[0] red, col[1] green, col[2] blue, col[3] alpha
   typedef struct packed {
      logic [POS_W-1:0]            pos;
      logic [3:0][COL_W-1:0]       col;
   } stop_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_MUL,
      S_TEST,
      S_DIV,
      S_CMUL,
      S_CADD,
      S_CSCL,
      S_DONE
   } state_type;

endpackage

[rtl/grti_chan_if.sv]
// Valid/ready channel carrying one payload beat.
interface grti_chan_if #(
   parameter type payload_type = logic
);
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

[rtl/gradient_ramp_texel_interpolator_top.sv]
// Gradient ramp texel interpolator: a stop store and one shared multiplier under a sequencer.
// A stop write goes into the store when it is accepted. A texel request scans the stops,
// each stop tested in S_MUL (the position times TEXELS-1 product on the shared multiplier,
// while the next stop is read) and then S_TEST (its compare), then runs a 17-step restoring
// divide for the weight when it lands between two stops, then S_CMUL, S_CADD and S_CSCL for
// each color channel, the multiply of S_CMUL on the same multiplier. The input is not
// ready during that work; a finished result waits in the output register while the next
// beat is taken. The stop store has no reset; read only slots that were written.
module gradient_ramp_texel_interpolator_top
   import grti_pkg::*;
#(
   parameter int MAX_STOPS = MAX_STOPS_DEF,
   parameter int TEXELS    = TEXELS_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_wr_en,
   input  logic [CNT_CFG_W-1:0] csr_wr_data,
   grti_chan_if.sink            req_chan,
   grti_chan_if.source          rsp_chan
);

   localparam int SIDX_W = (MAX_STOPS > 1) ? $clog2(MAX_STOPS) : 1;
   localparam int CNT_W  = $clog2(MAX_STOPS + 1);
   localparam int DCNT_W = $clog2(W_W);
   localparam logic [POS_W-1:0]  D_VAL    = POS_W'(TEXELS - 1);
   localparam logic [CNT_W-1:0]  MAX_CNT  = CNT_W'(MAX_STOPS);
   localparam logic [DCNT_W-1:0] DIV_LAST = DCNT_W'(W_W - 1);
   localparam logic [W_W-1:0]    W_ONE    = W_W'(1) << POS_W;

   stop_type                     mem [MAX_STOPS];
   stop_type                     rd_ff;
   logic                         rd_en;
   logic [SIDX_W-1:0]            rd_addr;
   logic                         wr_en;
   logic [SIDX_W-1:0]            wr_addr;
   stop_type                     wr_data;

   state_type                    state_ff, state_in;
   logic [CNT_CFG_W-1:0]         stop_count_ff;
   logic [CNT_W-1:0]             n_val;
   logic [CNT_W-1:0]             j_ff, j_in, j_next;
   logic [PROD_W-1:0]            scaled_ff, scaled_in;
   logic [IDX_W-1:0]             index_ff, index_in;
   stop_type                     cur_ff, cur_in, prev_ff, prev_in;
   logic [PROD_W-1:0]            cur_prod_ff, cur_prod_in, prev_prod_ff, prev_prod_in;
   logic                         interp_ff, interp_in;
   logic [PROD_W-1:0]            rem_ff, rem_in, den_ff, den_in;
   logic [W_W-1:0]               w_ff, w_in;
   logic [DCNT_W-1:0]            dcnt_ff, dcnt_in;
   logic [1:0]                   ch_ff, ch_in;
   logic signed [2*MUL_W-1:0]    mul_ff, mul_in;
   logic [PROD_W-1:0]            c_ff, c_in;
   logic [3:0][OUT_W-1:0]        col_out_ff, col_out_in;
   logic                         rsp_valid_ff, rsp_valid_in;
   rsp_type                      rsp_ff, rsp_in;

   logic                         accept;
   logic                         rsp_load;
   logic [POS_W-1:0]             idx_clamp;
   logic [COL_W-1:0]             cp, cn;
   logic signed [COL_W:0]        diff;
   logic signed [MUL_W-1:0]      mul_a, mul_b;
   logic signed [2*MUL_W-1:0]    mul_p;
   logic [PROD_W:0]              rem_sh;
   logic                         ge;
   logic signed [2*MUL_W-1:0]    c_sum;
   logic [PROD_W+OUT_W-1:0]      scl;

   assign req_chan.ready  = (state_ff == S_IDLE);
   assign accept          = req_chan.valid && req_chan.ready;
   assign rsp_chan.valid  = rsp_valid_ff;
   assign rsp_chan.payload = rsp_ff;

   assign wr_en   = accept && (req_chan.payload.op == OP_WRITE)
                    && (32'(req_chan.payload.slot) < 32'(MAX_STOPS));
   assign wr_addr = SIDX_W'(req_chan.payload.slot);
   assign wr_data = '{pos: req_chan.payload.stop_position,
                      col: {req_chan.payload.stop_alpha, req_chan.payload.stop_blue,
                            req_chan.payload.stop_green, req_chan.payload.stop_red}};

   always_comb begin
      if (stop_count_ff == '0) begin
         n_val = CNT_W'(1);
      end else if (32'(stop_count_ff) > 32'(MAX_STOPS)) begin
         n_val = MAX_CNT;
      end else begin
         n_val = CNT_W'(stop_count_ff);
      end
   end

   assign j_next    = j_ff + CNT_W'(1);
   assign idx_clamp = (POS_W'(req_chan.payload.texel_index) > D_VAL) ? D_VAL
                      : POS_W'(req_chan.payload.texel_index);

   assign cp    = interp_ff ? prev_ff.col[ch_ff] : cur_ff.col[ch_ff];
   assign cn    = cur_ff.col[ch_ff];
   assign diff  = $signed({1'b0, cn}) - $signed({1'b0, cp});
   assign mul_p = mul_a * mul_b;

   always_comb begin
      mul_a = $signed({2'b0, rd_ff.pos});
      mul_b = $signed({2'b0, D_VAL});
      if (state_ff == S_CMUL) begin
         mul_a = MUL_W'(diff);
         mul_b = $signed({1'b0, w_ff});
      end
   end

   always_comb begin
      rd_en   = 1'b0;
      rd_addr = '0;
      if (state_ff == S_IDLE) begin
         rd_en = accept && (req_chan.payload.op == OP_TEXEL);
      end else if (state_ff == S_MUL) begin
         rd_en   = (j_next < n_val);
         rd_addr = SIDX_W'(j_next);
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_ff <= mem[rd_addr];
      end
   end

   assign rem_sh = (dcnt_ff == '0) ? {1'b0, rem_ff} : {rem_ff, 1'b0};
   assign ge     = (rem_sh >= {1'b0, den_ff});
   assign c_sum  = $signed({4'b0, cp, 16'b0}) + mul_ff;
   assign scl    = {c_ff, 8'b0} - {8'b0, c_ff};

   always_comb begin
      state_in     = state_ff;
      j_in         = j_ff;
      scaled_in    = scaled_ff;
      index_in     = index_ff;
      cur_in       = cur_ff;
      prev_in      = prev_ff;
      cur_prod_in  = cur_prod_ff;
      prev_prod_in = prev_prod_ff;
      interp_in    = interp_ff;
      rem_in       = rem_ff;
      den_in       = den_ff;
      w_in         = w_ff;
      dcnt_in      = dcnt_ff;
      ch_in        = ch_ff;
      mul_in       = mul_ff;
      c_in         = c_ff;
      col_out_in   = col_out_ff;
      rsp_load     = 1'b0;

      unique case (state_ff)
         S_IDLE: begin
            if (accept && (req_chan.payload.op == OP_TEXEL)) begin
               scaled_in = {idx_clamp, 16'b0};
               index_in  = req_chan.payload.texel_index;
               j_in      = '0;
               state_in  = S_MUL;
            end
         end
         S_MUL: begin
            prev_in      = cur_ff;
            prev_prod_in = cur_prod_ff;
            cur_in       = rd_ff;
            cur_prod_in  = mul_p[PROD_W-1:0];
            state_in     = S_TEST;
         end
         S_TEST: begin
            if (cur_prod_ff >= scaled_ff) begin
               w_in = '0;
               if (j_ff != '0) begin
                  interp_in = 1'b1;
                  rem_in    = scaled_ff - prev_prod_ff;
                  den_in    = cur_prod_ff - prev_prod_ff;
                  dcnt_in   = '0;
                  state_in  = S_DIV;
               end else begin
                  interp_in = 1'b0;
                  ch_in     = '0;
                  state_in  = S_CMUL;
               end
            end else if (j_next == n_val) begin
               interp_in = 1'b0;
               w_in      = '0;
               ch_in     = '0;
               state_in  = S_CMUL;
            end else begin
               j_in     = j_next;
               state_in = S_MUL;
            end
         end
         S_DIV: begin
            rem_in = ge ? PROD_W'(rem_sh - {1'b0, den_ff}) : rem_sh[PROD_W-1:0];
            w_in   = {w_ff[W_W-2:0], ge};
            if (dcnt_ff == DIV_LAST) begin
               ch_in    = '0;
               state_in = S_CMUL;
            end else begin
               dcnt_in = dcnt_ff + DCNT_W'(1);
            end
         end
         S_CMUL: begin
            mul_in   = mul_p;
            state_in = S_CADD;
         end
         S_CADD: begin
            c_in     = c_sum[PROD_W-1:0];
            state_in = S_CSCL;
         end
         S_CSCL: begin
            col_out_in[ch_ff] = scl[PROD_W+OUT_W-1:PROD_W];
            if (ch_ff == 2'd3) begin
               state_in = S_DONE;
            end else begin
               ch_in    = ch_ff + 2'd1;
               state_in = S_CMUL;
            end
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_chan.ready) begin
               rsp_load = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff;
      if (rsp_load) begin
         rsp_in       = '{out_index: index_ff, out_red: col_out_ff[0],
                          out_green: col_out_ff[1], out_blue: col_out_ff[2],
                          out_alpha: col_out_ff[3]};
         rsp_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         stop_count_ff <= CNT_CFG_W'(1);
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) begin
            stop_count_ff <= csr_wr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      j_ff         <= j_in;
      scaled_ff    <= scaled_in;
      index_ff     <= index_in;
      cur_ff       <= cur_in;
      prev_ff      <= prev_in;
      cur_prod_ff  <= cur_prod_in;
      prev_prod_ff <= prev_prod_in;
      interp_ff    <= interp_in;
      rem_ff       <= rem_in;
      den_ff       <= den_in;
      w_ff         <= w_in;
      dcnt_ff      <= dcnt_in;
      ch_ff        <= ch_in;
      mul_ff       <= mul_in;
      c_ff         <= c_in;
      col_out_ff   <= col_out_in;
      rsp_ff       <= rsp_in;
   end

   a_weight_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_CMUL) |-> (w_ff <= W_ONE))
      else $error("interpolation weight above one");

   a_weight_zero: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == S_CMUL) && !interp_ff) |-> (w_ff == '0))
      else $error("nonzero weight on a single-stop texel");

   a_scan_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_TEST) |-> (j_ff < n_val))
      else $error("stop scan beyond valid stop count");

   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == S_DONE))
      else $error("result beat raised outside completion");

endmodule
